[hdl/stroke_font_vector_generator_defines.svh]
// assertion macros for the stroke font vector generator
`ifndef STROKE_FONT_VECTOR_GENERATOR_DEFINES_SVH
`define STROKE_FONT_VECTOR_GENERATOR_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define SFVG_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication outside reset
`define SFVG_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);
`endif

[hdl/sfvg_pkg.sv]
// shared types, constants and glyph rom for the stroke font vector generator
`default_nettype none
package sfvg_pkg;
	localparam int GlyphPts = 12;
	localparam int PtIdxW = 4;

	typedef enum logic [2:0] {
		REG_UNIT_SCALE  = 3'd0,
		REG_TEXT_LENGTH = 3'd1,
		REG_CENTRE_X    = 3'd2,
		REG_CENTRE_Y    = 3'd3,
		REG_VERTICAL    = 3'd4,
		REG_MIRRORED    = 3'd5
	} reg_idx_t;

	// one glyph point: grid x, grid y, stroke start
	typedef struct packed {
		logic [2:0] gx;
		logic [2:0] gy;
		logic       start;
	} gpt_t;

	// queued job handed from front to back
	typedef struct packed {
		logic [7:0] code;
		logic [7:0] index;
	} job_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20 || c == 8'h85 || c == 8'hA0;
	endfunction

	function automatic logic [7:0] fold_upper(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
	endfunction

	// glyph path as a string of digits and bars, box for unknown codes
	function automatic string glyph_path(input logic [7:0] c);
		unique case (c)
			"0": return "0040460600|0640";
			"1": return "112026|0646";
			"2": return "004043030646";
			"3": return "00404606|0343";
			"4": return "000343|4046";
			"5": return "400003434606";
			"6": return "400006464303";
			"7": return "004016";
			"8": return "0040460600|0343";
			"9": return "4640000343";
			"A": return "0602204246|0444";
			"B": return "003041423303|334445360600";
			"C": return "40000646";
			"D": return "00304145360600";
			"E": return "40000646|0333";
			"F": return "400006|0333";
			"G": return "400006464323";
			"H": return "0006|4046|0343";
			"I": return "0040|2026|0646";
			"J": return "4045361605";
			"K": return "0006|400346";
			"L": return "000646";
			"M": return "0600224046";
			"N": return "06004640";
			"O": return "0040460600";
			"P": return "0600404303";
			"Q": return "0040460600|2446";
			"R": return "0600404303|2346";
			"S": return "400003434606";
			"T": return "0040|2026";
			"U": return "00064640";
			"V": return "002640";
			"W": return "0006244640";
			"X": return "0046|4006";
			"Y": return "0023|4023|2326";
			"Z": return "00400646";
			"-": return "0343";
			"_": return "0646";
			".": return "2526";
			"+": return "0343|2224";
			"/": return "0640";
			"?": return "0040432324|2526";
			":": return "2122|2425";
			"(": return "30212536";
			")": return "10212516";
			"=": return "0242|0444";
			"#": return "1016|3036|0242|0444";
			default: return "0040460600";
		endcase
	endfunction

	// point count of a glyph, capped at twelve
	function automatic logic [PtIdxW-1:0] glyph_count(input logic [7:0] c);
		string s;
		int n;
		s = glyph_path(c);
		n = 0;
		for (int i = 0; i < s.len(); i++) begin
			if (s[i] != "|") n++;
		end
		n = n / 2;
		if (n > GlyphPts) n = GlyphPts;
		return PtIdxW'(n);
	endfunction

	// k-th point of a glyph
	function automatic gpt_t glyph_point(input logic [7:0] c, input logic [PtIdxW-1:0] k);
		string s;
		int p;
		int n;
		logic st;
		gpt_t r;
		s = glyph_path(c);
		p = 0;
		n = 0;
		st = 1'b1;
		r = '0;
		while (p + 1 < s.len()) begin
			if (s[p] == "|") begin
				st = 1'b1;
				p++;
			end else begin
				if (n == int'(k)) begin
					r.gx = 3'(s[p] - "0");
					r.gy = 3'(s[p+1] - "0");
					r.start = st;
				end
				st = 1'b0;
				n++;
				p += 2;
			end
		end
		return r;
	endfunction
endpackage
`default_nettype wire

[hdl/sfvg_front.sv]
// front end: accepts characters, drops whitespace, folds case, queues jobs
`default_nettype none
module sfvg_front import sfvg_pkg::*; #(
	parameter int Depth = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_code,
	input  wire logic [7:0] in_index,
	output logic            job_valid,
	input  wire logic       job_ready,
	output job_t            job
);
	localparam int AW = $clog2(Depth);
	job_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign in_ready = cnt_q != (AW+1)'(Depth);
	assign push = in_valid && in_ready && !is_blank(in_code);
	assign job_valid = cnt_q != '0;
	assign pop = job_valid && job_ready;
	assign job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= '{code: fold_upper(in_code), index: in_index};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

[hdl/sfvg_back.sv]
// back end: walks glyph points, scales, turns, mirrors, offsets and saturates
`default_nettype none
`include "stroke_font_vector_generator_defines.svh"
module sfvg_back import sfvg_pkg::*; #(
	parameter int MaxChars = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               job_valid,
	output logic                    job_ready,
	input  job_t                    job,
	input  wire logic [15:0]        unit_scale,
	input  wire logic [8:0]         text_length,
	input  wire logic signed [31:0] centre_x,
	input  wire logic signed [31:0] centre_y,
	input  wire logic               vertical,
	input  wire logic               mirrored,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [71:0]             out_data,
	output logic                    out_last
);
	logic busy_q;
	job_t job_q;
	logic [PtIdxW-1:0] k_q, n_q;
	logic v_s1;
	logic signed [15:0] gxo_s1, gyo_s1;
	logic st_s1, last_s1;
	logic v_s2;
	logic signed [33:0] mx_s2, my_s2;
	logic st_s2, last_s2;
	logic adv1, adv2;
	gpt_t pt;
	logic [16:0] len_c;
	logic signed [15:0] xoff;
	logic signed [35:0] rx, ry, sx, sy;
	logic signed [31:0] ox, oy;

	function automatic logic signed [31:0] sat(input logic signed [35:0] v);
		if (v > 36'sh07FFFFFFF) return 32'sh7FFFFFFF;
		if (v < -36'sh080000000) return -32'sh80000000;
		return v[31:0];
	endfunction

	assign adv2 = !out_valid || out_ready;
	assign adv1 = !v_s2 || adv2;
	assign job_ready = !busy_q;
	assign pt = glyph_point(job_q.code, k_q);
	assign len_c = (17'(text_length) > 17'(MaxChars)) ? 17'(MaxChars) : 17'(text_length);
	assign xoff = (len_c == '0) ? 16'sd0 : 16'sd1 - 16'(3 * len_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q <= '0;
			n_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (!busy_q && job_valid) begin
				busy_q <= 1'b1;
				k_q <= '0;
				n_q <= glyph_count(job.code);
			end
			if (adv1) begin
				v_s1 <= busy_q;
				if (busy_q) begin
					k_q <= k_q + 1'b1;
					if (k_q + 1'b1 == n_q) busy_q <= 1'b0;
				end
			end
			if (adv1) v_s2 <= v_s1;
			if (adv2) out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && job_valid) job_q <= job;
		if (adv1) begin
			gxo_s1 <= 16'(6 * 16'(job_q.index)) + 16'(pt.gx) + xoff;
			gyo_s1 <= 16'(pt.gy) - 16'sd3;
			st_s1 <= pt.start;
			last_s1 <= (k_q + 1'b1 == n_q);
			mx_s2 <= gxo_s1 * $signed({1'b0, unit_scale});
			my_s2 <= gyo_s1 * $signed({1'b0, unit_scale});
			st_s2 <= st_s1;
			last_s2 <= last_s1;
		end
		if (adv2 && v_s2) begin
			out_data <= {7'd0, st_s2, oy, ox};
			out_last <= last_s2;
		end
	end

	always_comb begin
		rx = vertical ? 36'(my_s2) : 36'(mx_s2);
		ry = vertical ? -36'(mx_s2) : 36'(my_s2);
		if (mirrored) rx = -rx;
		sx = rx + 36'(centre_x);
		sy = ry + 36'(centre_y);
		ox = sat(sx);
		oy = sat(sy);
	end

	`SFVG_ASSERT_NXT(a_last_hold, clk, arst_n, out_valid && !out_ready, $stable(out_last), "last changed under stall")
	`SFVG_ASSERT_NXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "output dropped")
	`SFVG_ASSERT_IMP(a_busy_count, clk, arst_n, busy_q, k_q < n_q, "point walk overran")
endmodule
`default_nettype wire

[hdl/stroke_font_vector_generator.sv]
// top level of the stroke font vector generator
// channel | dir | beat contents
// s_axis  | in  | tdata[7:0] char_code, [15:8] char_index
// m_axis  | out | tdata[31:0] point_x, [63:32] point_y, [64] stroke_start, tlast last_point
// apb     | in  | six registers at 4*i
// one character queues in a cycle while the queue has room; the back end loads a job and then
// emits one point per cycle while the output is not stalled, and takes no new job until
// the point walk counter has walked every point of the glyph
// whitespace is dropped in the front and queues no job
// a two-entry queue lets the front accept while the back is drawing
// output register holds a point under back pressure; reset is asynchronous
`default_nettype none
module stroke_font_vector_generator import sfvg_pkg::*; #(
	parameter int MAX_TEXT_CHARS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // char_code, char_index
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [71:0]      m_axis_tdata,   // point_x, point_y, stroke_start, zero fill
	output logic             m_axis_tlast,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic [15:0] unit_scale_q;
	logic [8:0] text_length_q;
	logic [31:0] centre_x_q, centre_y_q;
	logic vertical_q, mirrored_q;
	logic job_valid, job_ready;
	job_t job;
	logic [2:0] ridx;

	assign pready = 1'b1;
	assign ridx = paddr[4:2];

	// register write on access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_scale_q <= 16'd256;
			text_length_q <= 9'd1;
			centre_x_q <= '0;
			centre_y_q <= '0;
			vertical_q <= 1'b0;
			mirrored_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
			unique case (ridx)
				REG_UNIT_SCALE:  unit_scale_q <= pwdata[15:0];
				REG_TEXT_LENGTH: text_length_q <= pwdata[8:0];
				REG_CENTRE_X:    centre_x_q <= pwdata;
				REG_CENTRE_Y:    centre_y_q <= pwdata;
				REG_VERTICAL:    vertical_q <= pwdata[0];
				REG_MIRRORED:    mirrored_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (ridx)
			REG_UNIT_SCALE:  prdata = {16'd0, unit_scale_q};
			REG_TEXT_LENGTH: prdata = {23'd0, text_length_q};
			REG_CENTRE_X:    prdata = centre_x_q;
			REG_CENTRE_Y:    prdata = centre_y_q;
			REG_VERTICAL:    prdata = {31'd0, vertical_q};
			REG_MIRRORED:    prdata = {31'd0, mirrored_q};
			default:         prdata = '0;
		endcase
	end

	sfvg_front #(.Depth(2)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_code(s_axis_tdata[7:0]), .in_index(s_axis_tdata[15:8]),
		.job_valid, .job_ready, .job
	);

	sfvg_back #(.MaxChars(MAX_TEXT_CHARS)) u_back (
		.clk, .arst_n, .job_valid, .job_ready, .job,
		.unit_scale(unit_scale_q), .text_length(text_length_q),
		.centre_x(centre_x_q), .centre_y(centre_y_q),
		.vertical(vertical_q), .mirrored(mirrored_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_data(m_axis_tdata), .out_last(m_axis_tlast)
	);
endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking testbench for the stroke font vector generator
`default_nettype none
module tb_top;
	import sfvg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// one expected glyph point
	typedef struct {
		logic [31:0] px;
		logic [31:0] py;
		logic        st;
		logic        lp;
	} glyph_pt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;   // char_code, char_index
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;        // point_x, point_y, stroke_start, zero fill
	logic m_axis_tlast;               // last_point
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	stroke_font_vector_generator uut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow copy of the registers
	logic [15:0] scale_q = 16'd256;
	logic [8:0] len_q = 9'd1;
	logic signed [31:0] cx_q = 0;
	logic signed [31:0] cy_q = 0;
	logic vert_q = 1'b0;
	logic mirr_q = 1'b0;

	logic [15:0] char_q[$];       // characters waiting to be sent
	glyph_pt_t point_q[$];        // points still expected from the block
	int errors = 0;
	int idle_cycles = 0;
	bit hold_off = 1'b0;          // long receiver stall requested by stimulus
	bit hold_done = 1'b0;         // receiver finished its long stall
	int hold_cnt = 0;

	// ascii path string of a glyph, written independently of the rom function
	function automatic string stroke_path(input logic [7:0] c);
		case (c)
			8'h30: return "0040460600|0640";
			8'h31: return "112026|0646";
			8'h32: return "004043030646";
			8'h33: return "00404606|0343";
			8'h34: return "000343|4046";
			8'h35: return "400003434606";
			8'h36: return "400006464303";
			8'h37: return "004016";
			8'h38: return "0040460600|0343";
			8'h39: return "4640000343";
			8'h41: return "0602204246|0444";
			8'h42: return "003041423303|334445360600";
			8'h43: return "40000646";
			8'h44: return "00304145360600";
			8'h45: return "40000646|0333";
			8'h46: return "400006|0333";
			8'h47: return "400006464323";
			8'h48: return "0006|4046|0343";
			8'h49: return "0040|2026|0646";
			8'h4A: return "4045361605";
			8'h4B: return "0006|400346";
			8'h4C: return "000646";
			8'h4D: return "0600224046";
			8'h4E: return "06004640";
			8'h4F: return "0040460600";
			8'h50: return "0600404303";
			8'h51: return "0040460600|2446";
			8'h52: return "0600404303|2346";
			8'h53: return "400003434606";
			8'h54: return "0040|2026";
			8'h55: return "00064640";
			8'h56: return "002640";
			8'h57: return "0006244640";
			8'h58: return "0046|4006";
			8'h59: return "0023|4023|2326";
			8'h5A: return "00400646";
			8'h2D: return "0343";
			8'h5F: return "0646";
			8'h2E: return "2526";
			8'h2B: return "0343|2224";
			8'h2F: return "0640";
			8'h3F: return "0040432324|2526";
			8'h3A: return "2122|2425";
			8'h28: return "30212536";
			8'h29: return "10212516";
			8'h3D: return "0242|0444";
			8'h23: return "1016|3036|0242|0444";
			default: return "0040460600";
		endcase
	endfunction

	function automatic logic [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'h7FFFFFFF;
		if (v < -64'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	// expected points of one character under the current registers
	task automatic predict_points(input logic [7:0] code, input logic [7:0] pos);
		string s;
		longint len, xoff, gx, gy, x, y, t;
		int p, n;
		bit st;
		glyph_pt_t g;
		if ((code >= 8'h09 && code <= 8'h0D) || code == 8'h20 || code == 8'h85
			|| code == 8'hA0) return;
		if (code >= 8'h61 && code <= 8'h7A) code = code - 8'd32;
		len = len_q;
		if (len > 256) len = 256;
		xoff = (len > 0) ? 1 - 3 * len : 0;
		s = stroke_path(code);
		p = 0;
		n = 0;
		st = 1'b1;
		while (p < s.len() && n < 12) begin
			if (s[p] == "|") begin
				st = 1'b1;
				p++;
			end else if (p + 1 >= s.len()) begin
				break;
			end else begin
				gx = s[p] - "0";
				gy = s[p+1] - "0";
				p += 2;
				x = (6 * longint'(pos) + gx + xoff) * longint'(scale_q);
				y = (gy - 3) * longint'(scale_q);
				if (vert_q) begin
					t = x;
					x = y;
					y = -t;
				end
				if (mirr_q) x = -x;
				x += cx_q;
				y += cy_q;
				g.px = clamp32(x);
				g.py = clamp32(y);
				g.st = st;
				g.lp = 1'b0;
				point_q.push_back(g);
				st = 1'b0;
				n++;
			end
		end
		if (n > 0) point_q[$].lp = 1'b1;
	endtask

	// sender: feeds queued characters with random gaps
	int gap = 0;
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) predict_points(s_axis_tdata[7:0], s_axis_tdata[15:8]);
		if (s_axis_tvalid && !s_axis_tready) begin
			// keep the current beat
		end else if (gap > 0) begin
			gap <= gap - 1;
			s_axis_tvalid <= 1'b0;
		end else if (char_q.size() > 0 && arst_n) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= char_q.pop_front();
			gap <= ($urandom_range(0, 3) == 0) ?
				(($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3)) : 0;
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// receiver: random stalls plus one long hold-off, checks every point beat
	int stall = 0;
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (point_q.size() == 0) begin
				$error("point beat with nothing expected");
				errors++;
			end else begin
				if (m_axis_tdata[31:0] !== point_q[0].px) begin
					$error("point_x expected %h got %h", point_q[0].px, m_axis_tdata[31:0]);
					errors++;
				end
				if (m_axis_tdata[63:32] !== point_q[0].py) begin
					$error("point_y expected %h got %h", point_q[0].py, m_axis_tdata[63:32]);
					errors++;
				end
				if (m_axis_tdata[64] !== point_q[0].st) begin
					$error("stroke_start expected %b got %b", point_q[0].st, m_axis_tdata[64]);
					errors++;
				end
				if (m_axis_tlast !== point_q[0].lp) begin
					$error("last_point expected %b got %b", point_q[0].lp, m_axis_tlast);
					errors++;
				end
				void'(point_q.pop_front());
			end
		end
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_off && !hold_done) begin
			m_axis_tready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt >= 149) hold_done <= 1'b1;
		end else if (stall > 0) begin
			stall <= stall - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 4) == 0)
				stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| psel || hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// apb write: setup then access, shadow updated on the access edge
	task automatic reg_write(input reg_idx_t r, input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 5'(r) << 2;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			REG_UNIT_SCALE: scale_q = v[15:0];
			REG_TEXT_LENGTH: len_q = v[8:0];
			REG_CENTRE_X: cx_q = v;
			REG_CENTRE_Y: cy_q = v;
			REG_VERTICAL: vert_q = v[0];
			REG_MIRRORED: mirr_q = v[0];
			default: ;
		endcase
	endtask

	// wait until all queued characters are out and all points received
	task automatic drain();
		while (char_q.size() > 0 || s_axis_tvalid || point_q.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic send_char(input logic [7:0] c, input logic [7:0] pos);
		char_q.push_back({pos, c});
	endtask

	// random character: mostly glyphs, some lower case, blanks and unknowns
	function automatic logic [7:0] pick_code();
		string known = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ-_.+/?:()=#";
		case ($urandom_range(0, 9))
			0: return 8'($urandom_range(0, 255));
			1: return 8'($urandom_range(8'h61, 8'h7A));
			2: return 8'h20;
			default: return known[$urandom_range(0, known.len() - 1)];
		endcase
	endfunction

	initial begin
		string dir_codes = "0189ABMQRY#?:()=Wb";
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: reset settings, glyph variety, blanks, unknowns, index extremes
		for (int i = 0; i < dir_codes.len(); i++) send_char(dir_codes[i], 8'(i));
		send_char(8'h20, 0);
		send_char(8'h09, 1);
		send_char(8'h0D, 2);
		send_char(8'h85, 3);
		send_char(8'hA0, 4);
		send_char(8'hFF, 8'hFF);
		send_char(8'h00, 8'h00);
		send_char(8'h7A, 8'hAA);
		drain();

		// empty string and length beyond the limit, extreme scale and centre
		reg_write(REG_TEXT_LENGTH, 32'd0);
		reg_write(REG_UNIT_SCALE, 32'hFFFF);
		reg_write(REG_CENTRE_X, 32'h7FFFFFF0);
		reg_write(REG_CENTRE_Y, 32'h80000010);
		for (int i = 0; i < 8; i++) send_char(pick_code(), 8'($urandom_range(0, 255)));
		drain();
		reg_write(REG_TEXT_LENGTH, 32'd511);
		reg_write(REG_VERTICAL, 32'd1);
		reg_write(REG_MIRRORED, 32'd1);
		reg_write(REG_UNIT_SCALE, 32'd0);
		for (int i = 0; i < 6; i++) send_char(pick_code(), 8'($urandom_range(0, 255)));
		drain();

		// long receiver hold-off while the sender keeps offering
		hold_off = 1'b1;
		for (int i = 0; i < 12; i++) send_char(8'h42, 8'(i));
		wait (hold_done);
		hold_off = 1'b0;
		drain();

		// random phases with random register settings
		for (int ph = 0; ph < 8; ph++) begin
			reg_write(REG_UNIT_SCALE, (ph % 3 == 0) ? 32'($urandom_range(0, 65535))
				: 32'($urandom_range(0, 1024)));
			reg_write(REG_TEXT_LENGTH, 32'($urandom_range(0, 511)));
			reg_write(REG_CENTRE_X, (ph == 6) ? 32'h80000000 : $urandom());
			reg_write(REG_CENTRE_Y, (ph == 6) ? 32'h7FFFFFFF : 32'($urandom_range(0, 65535)));
			reg_write(REG_VERTICAL, 32'(ph[0]));
			reg_write(REG_MIRRORED, 32'(ph[1]));
			for (int i = 0; i < 50; i++) send_char(pick_code(), 8'($urandom_range(0, 255)));
			drain();
		end

		repeat (50) @(posedge clk);
		if (errors == 0 && point_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire
